// ===== rtl/axis_angle_vector_rotation_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the axis-angle rotation core
// Shared helpers so every checker writes its properties the same way.
// ----------------------------------------------------------------------------
`ifndef AXIS_ANGLE_VECTOR_ROTATION_CORE_DEFINES_SVH
`define AXIS_ANGLE_VECTOR_ROTATION_CORE_DEFINES_SVH

// Same-cycle implication, silenced while reset is asserted.
`define AAVR_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication with a fixed delay, silenced while reset is asserted.
`define AAVR_ASSERT_DELAY(label, clk, rst_n, ante, n, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked during reset.
`define AAVR_ASSERT_NEXT_NORST(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/aavr_pkg.sv =====
// ----------------------------------------------------------------------------
// aavr_pkg
// Constants, tables and rounding helper for the axis-angle rotation core.
// ----------------------------------------------------------------------------
package aavr_pkg;

    localparam int COORD_WIDTH_DEF  = 32;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_BITS       = 20;

    // Width of the CORDIC x, y and angle registers (Q2.30 plus headroom).
    localparam int ZW = 34;

    // Register stages from an accepted word to its result on the ports.
    localparam int LATENCY = 75;

    localparam logic signed [ZW-1:0] PI30     = 34'sd3373259426;
    localparam logic signed [ZW-1:0] HALFPI30 = 34'sd1686629713;
    localparam logic signed [ZW-1:0] KGAIN30  = 34'sd652032874;

    // atan(2^-i) in units of 2^-30 rad.
    localparam logic [31:0] ATAN_Q30 [0:31] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
        32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
        32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
        32'd262143,    32'd131071,    32'd65535,     32'd32767,
        32'd16383,     32'd8191,      32'd4095,      32'd2047,
        32'd1023,      32'd511,       32'd255,       32'd127,
        32'd63,        32'd31,        32'd15,        32'd7,
        32'd3,         32'd1,         32'd0,         32'd0
    };

    // Add one half of the dropped range, then shift right arithmetically.
    function automatic logic signed [63:0] rnd_half_up(input logic signed [63:0] v,
                                                       input int unsigned s);
        logic signed [63:0] half;
        half = (s == 0) ? 64'sd0 : (64'sd1 <<< (s - 1));
        return (v + half) >>> s;
    endfunction

endpackage

// ===== rtl/axis_angle_vector_rotation_core.sv =====
// ----------------------------------------------------------------------------
// axis_angle_vector_rotation_core
// Each accepted word returns, in order, with its own one-cycle result strobe.
// Throughput: one word per cycle outside reset; the 32 square-root stages
// and 31 divider stages set the depth, and every stage advances every cycle.
// Reset: synchronous, active low; clears the valid chain, busy is high during
// reset and falls in the cycle after release. The receiver cannot stall.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotation_core #(
    parameter int COORD_WIDTH  = aavr_pkg::COORD_WIDTH_DEF,
    parameter int CORDIC_STEPS = aavr_pkg::CORDIC_STEPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [COORD_WIDTH-1:0]   i_point_x,
    input  logic signed [COORD_WIDTH-1:0]   i_point_y,
    input  logic signed [COORD_WIDTH-1:0]   i_point_z,
    input  logic signed [COORD_WIDTH-1:0]   i_axis_x,
    input  logic signed [COORD_WIDTH-1:0]   i_axis_y,
    input  logic signed [COORD_WIDTH-1:0]   i_axis_z,
    input  logic signed [aavr_pkg::ANGLE_BITS-1:0] i_turn_angle,
    output logic                            o_strobe,
    output logic signed [COORD_WIDTH-1:0]   o_rotated_x,
    output logic signed [COORD_WIDTH-1:0]   o_rotated_y,
    output logic signed [COORD_WIDTH-1:0]   o_rotated_z,
    output logic                            o_axis_zero
);

    // Widths that follow from the coordinate width. FQ is the fraction width
    // of the quaternion, UW the width of one quaternion component and TW the
    // width of the intermediate product t = P * conj(q).
    localparam int CW  = COORD_WIDTH;
    localparam int NS  = CORDIC_STEPS;
    localparam int FQ  = ((62 - CW) < 30) ? (62 - CW) : 30;
    localparam int UW  = FQ + 2;
    localparam int TW  = CW + 2;
    localparam int LW  = $clog2(CW);
    localparam int XW  = CW + 31;
    localparam int ZW  = aavr_pkg::ZW;
    localparam int LAT = aavr_pkg::LATENCY;

    // Sideband word carried along the whole pipe: point, axis signs, zero
    // flag and the CORDIC quadrant flip.
    localparam int SB_NEG  = 3 * CW;
    localparam int SB_ZERO = 3 * CW + 3;
    localparam int SB_FLIP = 3 * CW + 4;
    localparam int SBW     = 3 * CW + 5;

    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (CW - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

    // ------------------------------------------------------------------
    // Handshake and valid chain. A word enters whenever start is high and
    // busy is low; busy is only high in and just after reset, because the
    // pipe moves every cycle and the result side never pushes back.
    // ------------------------------------------------------------------
    logic             accept;
    logic             r_busy;
    logic [LAT-1:0]   r_vld;

    assign accept   = start && !r_busy;
    assign busy     = r_busy;
    assign o_strobe = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_vld  <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[LAT-2:0], accept};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: register the word. Axis magnitudes, signs and the zero test
    // are formed here, and the half angle is folded into [-pi/2, pi/2] so
    // the CORDIC converges; a fold by pi negates sine and cosine later.
    // ------------------------------------------------------------------
    logic [CW-1:0]          n_mag [0:2];
    logic [2:0]             n_neg;
    logic                   n_zero;
    logic signed [ZW-1:0]   n_zin;
    logic signed [ZW-1:0]   n_zred;
    logic                   n_flip;
    logic [SBW-1:0]         n_sb;

    logic [SBW-1:0]         r_sb  [0:LAT-2];
    logic signed [ZW-1:0]   r_zr  [0:4];
    logic [CW-1:0]          r_mag1 [0:2];

    always_comb begin
        n_neg[0] = i_axis_x[CW-1];
        n_neg[1] = i_axis_y[CW-1];
        n_neg[2] = i_axis_z[CW-1];
        n_mag[0] = n_neg[0] ? CW'(-i_axis_x) : CW'(i_axis_x);
        n_mag[1] = n_neg[1] ? CW'(-i_axis_y) : CW'(i_axis_y);
        n_mag[2] = n_neg[2] ? CW'(-i_axis_z) : CW'(i_axis_z);
        n_zero   = (i_axis_x == '0) && (i_axis_y == '0) && (i_axis_z == '0);

        n_zin  = ZW'(i_turn_angle) <<< 13;
        n_zred = n_zin;
        n_flip = 1'b0;
        if (n_zin > aavr_pkg::HALFPI30) begin
            n_zred = n_zin - aavr_pkg::PI30;
            n_flip = 1'b1;
        end else if (n_zin < -aavr_pkg::HALFPI30) begin
            n_zred = n_zin + aavr_pkg::PI30;
            n_flip = 1'b1;
        end

        n_sb = {n_flip, n_zero, n_neg, i_point_z, i_point_y, i_point_x};
    end

    always_ff @(posedge i_clk) begin
        r_sb[0] <= n_sb;
        for (int s = 1; s < LAT - 1; s++) begin
            r_sb[s] <= r_sb[s-1];
        end
        r_zr[0] <= n_zred;
        for (int s = 1; s < 5; s++) begin
            r_zr[s] <= r_zr[s-1];
        end
        for (int l = 0; l < 3; l++) begin
            r_mag1[l] <= n_mag[l];
        end
    end

    // ------------------------------------------------------------------
    // Stages 2 and 3: scale all three magnitudes by one power of two so the
    // largest lands in [2^30, 2^31). The leading one of the OR of the
    // magnitudes is the leading one of the largest.
    // ------------------------------------------------------------------
    logic [CW-1:0]  n_mor;
    logic [LW-1:0]  n_lead;
    logic [CW-1:0]  r_mag2 [0:2];
    logic [LW-1:0]  r_lead2;

    always_comb begin
        n_mor  = r_mag1[0] | r_mag1[1] | r_mag1[2];
        n_lead = '0;
        for (int i = 0; i < CW; i++) begin
            if (n_mor[i]) begin
                n_lead = LW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lead2 <= n_lead;
        for (int l = 0; l < 3; l++) begin
            r_mag2[l] <= r_mag1[l];
        end
    end

    logic [XW-1:0]  n_ext [0:2];
    logic [30:0]    r_nrm3 [0:2];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_ext[l] = (XW'(r_mag2[l]) << 30) >> r_lead2;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            r_nrm3[l] <= n_ext[l][30:0];
        end
    end

    // Stages 4 and 5: squares, then their sum (always below 2^64).
    logic [61:0] r_sq4 [0:2];
    logic [30:0] r_nrm4 [0:2];
    logic [63:0] r_sum5;
    logic [30:0] r_nrm5 [0:2];

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            r_sq4[l]  <= r_nrm3[l] * r_nrm3[l];
            r_nrm4[l] <= r_nrm3[l];
            r_nrm5[l] <= r_nrm4[l];
        end
        r_sum5 <= 64'(r_sq4[0]) + 64'(r_sq4[1]) + 64'(r_sq4[2]);
    end

    // ------------------------------------------------------------------
    // Stages 6 to 37: integer square root, one result bit per stage, and
    // next to it the rotation-mode CORDIC, one iteration per stage for the
    // first CORDIC_STEPS stages and a plain hand-over after that.
    // ------------------------------------------------------------------
    logic [63:0]            r_qv    [0:31];
    logic [34:0]            r_qrem  [0:31];
    logic [31:0]            r_qroot [0:31];
    logic [30:0]            r_qmag  [0:31][0:2];
    logic signed [ZW-1:0]   r_cx    [0:31];
    logic signed [ZW-1:0]   r_cy    [0:31];
    logic signed [ZW-1:0]   r_cz    [0:31];

    for (genvar j = 0; j < 32; j++) begin : g_isq
        logic [63:0]            v_in;
        logic [34:0]            rem_in;
        logic [31:0]            root_in;
        logic [30:0]            qmag_in [0:2];
        logic [34:0]            rem_sh;
        logic [34:0]            trial;
        logic signed [ZW-1:0]   x_in;
        logic signed [ZW-1:0]   y_in;
        logic signed [ZW-1:0]   z_in;
        logic signed [ZW-1:0]   n_x;
        logic signed [ZW-1:0]   n_y;
        logic signed [ZW-1:0]   n_z;

        if (j == 0) begin : g_first
            assign v_in    = r_sum5;
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = aavr_pkg::KGAIN30;
            assign y_in    = '0;
            assign z_in    = r_zr[4];
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign qmag_in[l] = r_nrm5[l];
            end
        end else begin : g_next
            assign v_in    = r_qv[j-1];
            assign rem_in  = r_qrem[j-1];
            assign root_in = r_qroot[j-1];
            assign x_in    = r_cx[j-1];
            assign y_in    = r_cy[j-1];
            assign z_in    = r_cz[j-1];
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign qmag_in[l] = r_qmag[j-1][l];
            end
        end

        assign rem_sh = {rem_in[32:0], v_in[63-2*j -: 2]};
        assign trial  = {1'b0, root_in, 2'b01};

        always_comb begin
            n_x = x_in;
            n_y = y_in;
            n_z = z_in;
            if (j < NS) begin
                if (z_in >= 0) begin
                    n_x = x_in - (y_in >>> j);
                    n_y = y_in + (x_in >>> j);
                    n_z = z_in - ZW'(aavr_pkg::ATAN_Q30[j]);
                end else begin
                    n_x = x_in + (y_in >>> j);
                    n_y = y_in - (x_in >>> j);
                    n_z = z_in + ZW'(aavr_pkg::ATAN_Q30[j]);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_qv[j] <= v_in;
            if (rem_sh >= trial) begin
                r_qrem[j]  <= rem_sh - trial;
                r_qroot[j] <= {root_in[30:0], 1'b1};
            end else begin
                r_qrem[j]  <= rem_sh;
                r_qroot[j] <= {root_in[30:0], 1'b0};
            end
            for (int l = 0; l < 3; l++) begin
                r_qmag[j][l] <= qmag_in[l];
            end
            r_cx[j] <= n_x;
            r_cy[j] <= n_y;
            r_cz[j] <= n_z;
        end
    end

    // ------------------------------------------------------------------
    // Stage 38: dividend of each unit component, mag * 2^30 + len / 2, and
    // the quadrant correction of sine and cosine.
    // ------------------------------------------------------------------
    logic [61:0]            r_dn [0:2];
    logic [31:0]            r_len;
    logic signed [ZW-1:0]   r_dsn;
    logic signed [ZW-1:0]   r_dcs;

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            r_dn[l] <= 62'({r_qmag[31][l], 30'b0}) + 62'(r_qroot[31] >> 1);
        end
        r_len <= r_qroot[31];
        r_dsn <= r_sb[36][SB_FLIP] ? -r_cy[31] : r_cy[31];
        r_dcs <= r_sb[36][SB_FLIP] ? -r_cx[31] : r_cx[31];
    end

    // ------------------------------------------------------------------
    // Stages 39 to 69: restoring division, one quotient bit per stage for
    // the three components in parallel. The quotient never exceeds 2^30,
    // so the top thirty-one dividend bits start out below the divisor.
    // ------------------------------------------------------------------
    logic [31:0]            r_vrem [0:30][0:2];
    logic [30:0]            r_vq   [0:30][0:2];
    logic [61:0]            r_vn   [0:30][0:2];
    logic [31:0]            r_vlen [0:30];
    logic signed [ZW-1:0]   r_vsn  [0:30];
    logic signed [ZW-1:0]   r_vcs  [0:30];

    for (genvar k = 0; k < 31; k++) begin : g_div
        logic [31:0]            len_in;
        logic [61:0]            num_in [0:2];
        logic [31:0]            rem_in [0:2];
        logic [30:0]            q_in   [0:2];
        logic [32:0]            rem_sh [0:2];
        logic signed [ZW-1:0]   sn_in;
        logic signed [ZW-1:0]   cs_in;

        if (k == 0) begin : g_first
            assign len_in = r_len;
            assign sn_in  = r_dsn;
            assign cs_in  = r_dcs;
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign num_in[l] = r_dn[l];
                assign rem_in[l] = 32'(r_dn[l][61:31]);
                assign q_in[l]   = '0;
            end
        end else begin : g_next
            assign len_in = r_vlen[k-1];
            assign sn_in  = r_vsn[k-1];
            assign cs_in  = r_vcs[k-1];
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign num_in[l] = r_vn[k-1][l];
                assign rem_in[l] = r_vrem[k-1][l];
                assign q_in[l]   = r_vq[k-1][l];
            end
        end

        for (genvar l = 0; l < 3; l++) begin : g_sh
            assign rem_sh[l] = {rem_in[l], num_in[l][30-k]};
        end

        always_ff @(posedge i_clk) begin
            for (int l = 0; l < 3; l++) begin
                r_vn[k][l] <= num_in[l];
                if (rem_sh[l] >= {1'b0, len_in}) begin
                    r_vrem[k][l] <= 32'(rem_sh[l] - {1'b0, len_in});
                    r_vq[k][l]   <= {q_in[l][29:0], 1'b1};
                end else begin
                    r_vrem[k][l] <= rem_sh[l][31:0];
                    r_vq[k][l]   <= {q_in[l][29:0], 1'b0};
                end
            end
            r_vlen[k] <= len_in;
            r_vsn[k]  <= sn_in;
            r_vcs[k]  <= cs_in;
        end
    end

    // ------------------------------------------------------------------
    // Stages 70 and 71: signed unit axis times sine, then both roundings
    // down to the quaternion fraction width. The cosine becomes w.
    // ------------------------------------------------------------------
    logic signed [32:0]     n_nsg [0:2];
    logic signed [66:0]     n_nsp [0:2];
    logic signed [63:0]     r_nsp [0:2];
    logic signed [ZW-1:0]   r_cs70;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_nsg[l] = r_sb[68][SB_NEG+l] ? -$signed({2'b00, r_vq[30][l]})
                                          :  $signed({2'b00, r_vq[30][l]});
            n_nsp[l] = n_nsg[l] * r_vsn[30];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            r_nsp[l] <= 64'(n_nsp[l]);
        end
        r_cs70 <= r_vcs[30];
    end

    logic signed [UW-1:0] r_u71 [0:2];
    logic signed [UW-1:0] r_w71;

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            r_u71[l] <= UW'(aavr_pkg::rnd_half_up(aavr_pkg::rnd_half_up(r_nsp[l], 30),
                                                  30 - FQ));
        end
        r_w71 <= UW'(aavr_pkg::rnd_half_up(64'(r_cs70), 30 - FQ));
    end

    // ------------------------------------------------------------------
    // Stages 72 and 73: t = P * conj(q). Product order per row:
    // tw = p.u; t0 = w p0 - p1 u2 + p2 u1, and cyclic for t1 and t2.
    // ------------------------------------------------------------------
    logic signed [CW-1:0]       n_p [0:2];
    logic signed [CW+UW-1:0]    n_pa [0:11];
    logic signed [63:0]         r_pa [0:11];
    logic signed [UW-1:0]       r_u72 [0:2];
    logic signed [UW-1:0]       r_w72;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_p[l] = $signed(r_sb[70][l*CW +: CW]);
        end
        n_pa[0]  = n_p[0] * r_u71[0];
        n_pa[1]  = n_p[1] * r_u71[1];
        n_pa[2]  = n_p[2] * r_u71[2];
        n_pa[3]  = n_p[0] * r_w71;
        n_pa[4]  = n_p[1] * r_u71[2];
        n_pa[5]  = n_p[2] * r_u71[1];
        n_pa[6]  = n_p[1] * r_w71;
        n_pa[7]  = n_p[2] * r_u71[0];
        n_pa[8]  = n_p[0] * r_u71[2];
        n_pa[9]  = n_p[2] * r_w71;
        n_pa[10] = n_p[0] * r_u71[1];
        n_pa[11] = n_p[1] * r_u71[0];
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 12; i++) begin
            r_pa[i] <= 64'(n_pa[i]);
        end
        r_u72 <= r_u71;
        r_w72 <= r_w71;
    end

    logic signed [TW-1:0] r_tw;
    logic signed [TW-1:0] r_t [0:2];
    logic signed [UW-1:0] r_u73 [0:2];
    logic signed [UW-1:0] r_w73;

    always_ff @(posedge i_clk) begin
        r_tw   <= TW'(aavr_pkg::rnd_half_up(r_pa[0] + r_pa[1] + r_pa[2], FQ));
        r_t[0] <= TW'(aavr_pkg::rnd_half_up(r_pa[3] - r_pa[4] + r_pa[5], FQ));
        r_t[1] <= TW'(aavr_pkg::rnd_half_up(r_pa[6] - r_pa[7] + r_pa[8], FQ));
        r_t[2] <= TW'(aavr_pkg::rnd_half_up(r_pa[9] - r_pa[10] + r_pa[11], FQ));
        r_u73  <= r_u72;
        r_w73  <= r_w72;
    end

    // ------------------------------------------------------------------
    // Stages 74 and 75: vector part of q * t. The sums wrap modulo 2^64
    // before rounding and saturation, exactly as a 64-bit accumulator.
    // ------------------------------------------------------------------
    logic signed [UW+TW-1:0] n_pb [0:11];
    logic signed [63:0]      r_pb [0:11];

    always_comb begin
        n_pb[0]  = r_w73    * r_t[0];
        n_pb[1]  = r_u73[0] * r_tw;
        n_pb[2]  = r_u73[1] * r_t[2];
        n_pb[3]  = r_u73[2] * r_t[1];
        n_pb[4]  = r_w73    * r_t[1];
        n_pb[5]  = r_u73[1] * r_tw;
        n_pb[6]  = r_u73[2] * r_t[0];
        n_pb[7]  = r_u73[0] * r_t[2];
        n_pb[8]  = r_w73    * r_t[2];
        n_pb[9]  = r_u73[2] * r_tw;
        n_pb[10] = r_u73[0] * r_t[1];
        n_pb[11] = r_u73[1] * r_t[0];
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 12; i++) begin
            r_pb[i] <= 64'(n_pb[i]);
        end
    end

    logic signed [63:0]     n_rr  [0:2];
    logic signed [CW-1:0]   n_sat [0:2];
    logic signed [CW-1:0]   n_pt  [0:2];
    logic signed [CW-1:0]   r_out [0:2];
    logic                   r_zero_out;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            n_rr[l] = aavr_pkg::rnd_half_up(r_pb[4*l] + r_pb[4*l+1] + r_pb[4*l+2]
                                            - r_pb[4*l+3], FQ);
            if (n_rr[l] > SAT_HI) begin
                n_sat[l] = CW'(SAT_HI);
            end else if (n_rr[l] < SAT_LO) begin
                n_sat[l] = CW'(SAT_LO);
            end else begin
                n_sat[l] = CW'(n_rr[l]);
            end
            n_pt[l] = $signed(r_sb[73][l*CW +: CW]);
        end
    end

    // A zero-length axis bypasses the arithmetic: the point goes out as is.
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            r_out[l] <= r_sb[73][SB_ZERO] ? n_pt[l] : n_sat[l];
        end
        r_zero_out <= r_sb[73][SB_ZERO];
    end

    assign o_rotated_x = r_out[0];
    assign o_rotated_y = r_out[1];
    assign o_rotated_z = r_out[2];
    assign o_axis_zero = r_zero_out;

endmodule

// ===== rtl/aavr_checker.sv =====
// ----------------------------------------------------------------------------
// aavr_checker
// Port-level checks of the rotation core's handshake, latency and bypass.
// ----------------------------------------------------------------------------
`include "axis_angle_vector_rotation_core_defines.svh"

module aavr_checker #(
    parameter int CW  = aavr_pkg::COORD_WIDTH_DEF,
    parameter int LAT = aavr_pkg::LATENCY
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic signed [CW-1:0] i_point_x,
    input logic                 o_strobe,
    input logic                 o_axis_zero,
    input logic signed [CW-1:0] o_rotated_x
);

    // Busy is raised by reset and dropped in the cycle after reset is released.
    `AAVR_ASSERT_NEXT_NORST(a_busy_in_reset, i_clk, !i_rst_n, busy, "busy low after reset cycle")
    `AAVR_ASSERT(a_ready_after_reset, i_clk, i_rst_n, $past(i_rst_n), !busy, "busy high in run")

    // Every accepted word yields exactly one result after the fixed latency.
    `AAVR_ASSERT_DELAY(a_word_out, i_clk, i_rst_n, start && !busy, LAT, o_strobe, "result lost")
    `AAVR_ASSERT(a_no_extra, i_clk, i_rst_n, o_strobe, $past(start && !busy, LAT), "extra result")

    // A zero axis returns the point that came in with it.
    `AAVR_ASSERT(a_zero_pass, i_clk, i_rst_n, o_strobe && o_axis_zero,
        o_rotated_x == $past(i_point_x, LAT), "zero axis bypass wrong")

endmodule

bind axis_angle_vector_rotation_core aavr_checker #(
    .CW  (COORD_WIDTH),
    .LAT (aavr_pkg::LATENCY)
) u_aavr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_point_x   (i_point_x),
    .o_strobe    (o_strobe),
    .o_axis_zero (o_axis_zero),
    .o_rotated_x (o_rotated_x)
);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Axis-angle vector rotation core testbench
// Drives points, axes and angles through the start/busy handshake with random
// gaps. A bit-exact integer predictor (quaternion built from a CORDIC sine
// and cosine, then q * P * conj(q)) computes each expected rotated point.
// Every strobed result is checked against the oldest pending expectation.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW        = aavr_pkg::COORD_WIDTH_DEF;
    localparam int STEPS     = aavr_pkg::CORDIC_STEPS_DEF;
    localparam int ANGLE_BITS = aavr_pkg::ANGLE_BITS;
    localparam int LAT       = aavr_pkg::LATENCY;
    localparam int FRACQ     = ((62 - CW) < 30) ? (62 - CW) : 30;
    localparam int IDLE_LIMIT = 4000;

    // One input word and one rotated result.
    typedef struct {
        logic signed [CW-1:0]         px, py, pz;
        logic signed [CW-1:0]         ax, ay, az;
        logic signed [ANGLE_BITS-1:0] ang;
        bit                           hold_for_drain;
    } t_rot_word;

    typedef struct {
        logic signed [CW-1:0] rx, ry, rz;
        logic                 zero_flag;
    } t_rot_result;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic signed [CW-1:0]         i_point_x = '0, i_point_y = '0, i_point_z = '0;
    logic signed [CW-1:0]         i_axis_x = '0, i_axis_y = '0, i_axis_z = '0;
    logic signed [ANGLE_BITS-1:0] i_turn_angle = '0;
    logic                         o_strobe;
    logic signed [CW-1:0]         o_rotated_x, o_rotated_y, o_rotated_z;
    logic                         o_axis_zero;

    t_rot_word   word_queue[$];
    t_rot_result expected_rotations[$];
    int          error_count = 0;
    int          idle_cycles = 0;

    axis_angle_vector_rotation_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_point_z    (i_point_z),
        .i_axis_x     (i_axis_x),
        .i_axis_y     (i_axis_y),
        .i_axis_z     (i_axis_z),
        .i_turn_angle (i_turn_angle),
        .o_strobe     (o_strobe),
        .o_rotated_x  (o_rotated_x),
        .o_rotated_y  (o_rotated_y),
        .o_rotated_z  (o_rotated_z),
        .o_axis_zero  (o_axis_zero)
    );

    always #5 i_clk = ~i_clk;

    // Round half up: add one half of the dropped range, shift arithmetically.
    function automatic longint half_up(longint v, int s);
        if (s == 0) begin
            return v;
        end
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // Floor of the square root of an unsigned 64-bit value, digit by digit.
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) begin
            b = b >> 2;
        end
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Expected output for one word. All sums wrap at 64 bits, as the
    // hardware datapath does.
    function automatic t_rot_result rotate_point(t_rot_word w);
        t_rot_result     res;
        longint          p[3], a[3], u[3], t[3], r[3], v[3];
        longint unsigned mag[3], m, sum, len;
        longint          z, x, y, dx, dy, sn, cs, n, tw, q_w, hi, lo;
        bit              flip;
        p[0] = w.px; p[1] = w.py; p[2] = w.pz;
        a[0] = w.ax; a[1] = w.ay; a[2] = w.az;

        // A zero-length axis returns the point as it came in.
        if (a[0] == 0 && a[1] == 0 && a[2] == 0) begin
            res.rx = w.px; res.ry = w.py; res.rz = w.pz;
            res.zero_flag = 1'b1;
            return res;
        end

        // Scale the axis magnitudes so the largest lies in [2^30, 2^31).
        m = 0;
        for (int k = 0; k < 3; k++) begin
            mag[k] = (a[k] < 0) ? longint'(-a[k]) : longint'(a[k]);
            if (mag[k] > m) m = mag[k];
        end
        while (m >= (64'd1 << 31)) begin
            m = m >> 1;
            for (int k = 0; k < 3; k++) mag[k] = mag[k] >> 1;
        end
        while (m < (64'd1 << 30)) begin
            m = m << 1;
            for (int k = 0; k < 3; k++) mag[k] = mag[k] << 1;
        end
        sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        len = floor_sqrt(sum);

        // Half angle in Q2.30, folded into [-pi/2, pi/2], then CORDIC.
        z = longint'(w.ang) * 8192;
        x = longint'(aavr_pkg::KGAIN30);
        y = 0;
        flip = 1'b0;
        if (z > longint'(aavr_pkg::HALFPI30)) begin
            z = z - longint'(aavr_pkg::PI30);
            flip = 1'b1;
        end else if (z < -longint'(aavr_pkg::HALFPI30)) begin
            z = z + longint'(aavr_pkg::PI30);
            flip = 1'b1;
        end
        for (int i = 0; i < STEPS && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(aavr_pkg::ATAN_Q30[i]);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(aavr_pkg::ATAN_Q30[i]);
            end
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;

        for (int k = 0; k < 3; k++) begin
            n = longint'(((mag[k] << 30) + (len >> 1)) / len);
            if (a[k] < 0) n = -n;
            u[k] = half_up(half_up(n * sn, 30), 30 - FRACQ);
        end
        q_w = half_up(cs, 30 - FRACQ);

        // t = P * conj(q), rounded back to coordinate units.
        tw   = half_up(p[0] * u[0] + p[1] * u[1] + p[2] * u[2], FRACQ);
        t[0] = half_up(q_w * p[0] - p[1] * u[2] + p[2] * u[1], FRACQ);
        t[1] = half_up(q_w * p[1] - p[2] * u[0] + p[0] * u[2], FRACQ);
        t[2] = half_up(q_w * p[2] - p[0] * u[1] + p[1] * u[0], FRACQ);

        // Vector part of q * t.
        r[0] = q_w * t[0] + tw * u[0] + u[1] * t[2] - u[2] * t[1];
        r[1] = q_w * t[1] + tw * u[1] + u[2] * t[0] - u[0] * t[2];
        r[2] = q_w * t[2] + tw * u[2] + u[0] * t[1] - u[1] * t[0];

        hi = (longint'(1) <<< (CW - 1)) - 1;
        lo = -hi - 1;
        for (int k = 0; k < 3; k++) begin
            v[k] = half_up(r[k], FRACQ);
            if (v[k] > hi) v[k] = hi;
            if (v[k] < lo) v[k] = lo;
        end
        res.rx = v[0][CW-1:0];
        res.ry = v[1][CW-1:0];
        res.rz = v[2][CW-1:0];
        res.zero_flag = 1'b0;
        return res;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic add_word(longint px, longint py, longint pz, longint ax, longint ay,
                            longint az, longint ang);
        t_rot_word w;
        w.px = px[CW-1:0]; w.py = py[CW-1:0]; w.pz = pz[CW-1:0];
        w.ax = ax[CW-1:0]; w.ay = ay[CW-1:0]; w.az = az[CW-1:0];
        w.ang = ang[ANGLE_BITS-1:0];
        w.hold_for_drain = 1'b0;
        word_queue.push_back(w);
    endtask

    // Coordinate with a random magnitude class, so both tiny and huge values
    // show up often.
    function automatic longint rand_coord();
        case ($urandom_range(0, 5))
            0: return longint'($signed($urandom_range(0, 255))) - 128;
            1: return longint'($signed($urandom() >> 8)) - (longint'(1) <<< 23);
            2: return $urandom_range(0, 1) ? longint'(32'sh7fffffff) : -longint'(1) <<< 31;
            default: return longint'($signed($urandom()));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver. A word is taken at an edge where start is high and busy low.
    // After each taken word a random gap is drawn, except during gapless
    // bursts. A word marked hold_for_drain is not offered until all
    // earlier results are back.
    // ------------------------------------------------------------------
    int        gap_left = 0;
    int        words_taken = 0;
    bit        gapless = 1'b0;
    t_rot_word next_word;

    always @(posedge i_clk) begin
        bit fire;
        fire = start && !busy;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (fire) begin
                expected_rotations.push_back(rotate_point(next_word));
                words_taken++;
                if (words_taken % 40 == 0) gapless = ~gapless;
                gap_left = gapless ? 0 : $urandom_range(0, 6);
            end
            if (fire || !start) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (word_queue.size() == 0) begin
                    start <= 1'b0;
                end else if (word_queue[0].hold_for_drain && expected_rotations.size() != 0) begin
                    start <= 1'b0;
                end else begin
                    next_word = word_queue.pop_front();
                    i_point_x    <= next_word.px;
                    i_point_y    <= next_word.py;
                    i_point_z    <= next_word.pz;
                    i_axis_x     <= next_word.ax;
                    i_axis_y     <= next_word.ay;
                    i_axis_z     <= next_word.az;
                    i_turn_angle <= next_word.ang;
                    start        <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor. Each strobe carries one result, checked field by field.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rot_result want;
        if (i_rst_n && o_strobe) begin
            if (expected_rotations.size() == 0) begin
                report("unexpected result word", o_rotated_x, 0);
            end else begin
                want = expected_rotations.pop_front();
                if (o_rotated_x !== want.rx) report("rotated_x", o_rotated_x, want.rx);
                if (o_rotated_y !== want.ry) report("rotated_y", o_rotated_y, want.ry);
                if (o_rotated_z !== want.rz) report("rotated_z", o_rotated_z, want.rz);
                if (o_axis_zero !== want.zero_flag)
                    report("axis_zero", o_axis_zero, want.zero_flag);
            end
        end
    end

    // Watchdog: cycles with neither a taken word nor a result.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Watchdog expired at %0t", $realtime);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    localparam longint MAXC = 64'sh7fffffff;
    localparam longint MINC = -64'sh80000000;
    localparam longint ONE  = 64'sd65536;

    initial begin
        longint ax, ay, az;
        // Directed words: zero axis, extremes, each axis, angle folds.
        add_word(MAXC, MINC, 12345, 0, 0, 0, 77);
        add_word(MINC, MAXC, -1, 0, 0, 0, -524288);
        add_word(ONE, 0, 0, 0, 0, ONE, 0);
        add_word(ONE, 2 * ONE, 3 * ONE, 0, 0, ONE, 205887);   // just below the fold
        add_word(ONE, 2 * ONE, 3 * ONE, 0, 0, ONE, 205888);   // just above the fold
        add_word(ONE, 2 * ONE, 3 * ONE, ONE, 0, 0, -205888);
        add_word(ONE, 2 * ONE, 3 * ONE, ONE, 0, 0, -205889);
        add_word(0, ONE, 0, 0, ONE, 0, 524287);
        add_word(0, ONE, 0, 0, -ONE, 0, -524288);
        add_word(ONE, ONE, ONE, 1, 0, 0, 102943);           // tiny axis scales up
        add_word(ONE, ONE, ONE, MINC, MINC, MINC, 102943);  // huge axis scales down
        add_word(MAXC, MAXC, MAXC, 1, 1, 0, 102943);        // rotated past full scale
        add_word(MINC, MINC, MINC, -1, 1, 0, -102943);
        add_word(MAXC, MINC, MAXC, MAXC, MAXC, MAXC, 411774);
        add_word(-ONE, 5, -7, -3, 4, -5, 0);
        add_word(0, 0, 0, MAXC, -1, 7, 300000);
        add_word(123456789, -987654321, 55555, 0, 0, MINC, 524287);
        add_word(-7 * ONE, 3 * ONE, ONE / 2, ONE, ONE, ONE, -411774);

        // Random words. Mostly proper axes, some zero or single-component.
        for (int i = 0; i < 640; i++) begin
            ax = rand_coord(); ay = rand_coord(); az = rand_coord();
            case ($urandom_range(0, 9))
                0: begin ax = 0; ay = 0; az = 0; end
                1: begin ay = 0; az = 0; end
                2: begin ax = 0; az = 0; end
                3: begin ax = 0; ay = 0; end
                default: ;
            endcase
            add_word(rand_coord(), rand_coord(), rand_coord(), ax, ay, az,
                     $urandom_range(0, (1 << ANGLE_BITS) - 1));
            // Let the pipeline drain completely before a few words.
            if (i % 200 == 100) word_queue[$].hold_for_drain = 1'b1;
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (word_queue.size() != 0 || start) @(posedge i_clk);
        while (expected_rotations.size() != 0) @(posedge i_clk);
        repeat (LAT + 20) @(posedge i_clk);

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/aavr_pkg.sv
rtl/axis_angle_vector_rotation_core.sv
rtl/aavr_checker.sv
bench/testbench.sv
